// File: src/pep_pkg.sv
package pep_pkg;

    // Sector geometry: byte offsets turn into sectors by a shift
    localparam int SECTOR_BYTES = 2048;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    localparam int PRIO_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int FSS_W    = 24;
    localparam int BYTE_W   = 31;
    localparam int SECTOR_W = 25;
    localparam int LAST_W   = 26;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PICK   = 2'd2
    } t_pep_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_pep_state;

    // Input word
    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] priority_req;
        logic [FSS_W-1:0]  file_start_sector;
        logic [BYTE_W-1:0] byte_offset;
        logic [BYTE_W-1:0] byte_size;
    } t_pep_in;

    // Result word
    typedef struct packed {
        logic [SLOT_W-1:0] picked_slot;
        logic              found;
    } t_pep_out;

    // Table update for one cell
    typedef struct packed {
        logic                ins;
        logic                rem;
        logic [PRIO_W-1:0]   prio;
        logic [SECTOR_W-1:0] start_sec;
        logic [SECTOR_W-1:0] end_sec;
    } t_pep_wr;

    // Search token handed from cell to cell during a pick
    typedef struct packed {
        logic                run;
        logic                any;
        logic [PRIO_W-1:0]   top;
        logic                have_fwd;
        logic [SECTOR_W-1:0] fwd_start;
        logic [SECTOR_W-1:0] fwd_end;
        logic [SECTOR_W-1:0] small_start;
        logic [SECTOR_W-1:0] small_end;
    } t_pep_tok;

endpackage

// File: src/pep_cell.sv
module pep_cell
    import pep_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pep_wr                  i_wr,
    input  logic [PRIO_W-1:0]        i_min_prio,
    input  logic signed [LAST_W-1:0] i_last,
    input  t_pep_tok                 i_tok,
    input  logic [IDX_W-1:0]         i_fwd_idx,
    input  logic [IDX_W-1:0]         i_small_idx,
    output t_pep_tok                 o_tok,
    output logic [IDX_W-1:0]         o_fwd_idx,
    output logic [IDX_W-1:0]         o_small_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                r_valid;
    logic [PRIO_W-1:0]   r_prio;
    logic [SECTOR_W-1:0] r_start;
    logic [SECTOR_W-1:0] r_end;

    t_pep_tok            r_tok;
    t_pep_tok            n_tok;
    logic [IDX_W-1:0]    r_fwd_idx;
    logic [IDX_W-1:0]    n_fwd_idx;
    logic [IDX_W-1:0]    r_small_idx;
    logic [IDX_W-1:0]    n_small_idx;

    logic                elig;
    logic                fwd;

    // Hold the entry; insert overwrites, remove drops it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.ins) begin
            r_valid <= 1'b1;
        end else if (i_wr.rem) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.ins) begin
            r_prio  <= i_wr.prio;
            r_start <= i_wr.start_sec;
            r_end   <= i_wr.end_sec;
        end
    end

    // Fold this entry into the passing token
    always_comb begin
        elig        = r_valid && (r_prio >= i_min_prio);
        fwd         = $signed({1'b0, r_start}) >= i_last;
        n_tok       = i_tok;
        n_fwd_idx   = i_fwd_idx;
        n_small_idx = i_small_idx;
        if (i_tok.run && elig) begin
            if (!i_tok.any || (r_prio > i_tok.top)) begin
                n_tok.any         = 1'b1;
                n_tok.top         = r_prio;
                n_tok.have_fwd    = fwd;
                n_tok.fwd_start   = r_start;
                n_tok.fwd_end     = r_end;
                n_fwd_idx         = MY_IDX;
                n_tok.small_start = r_start;
                n_tok.small_end   = r_end;
                n_small_idx       = MY_IDX;
            end else if (r_prio == i_tok.top) begin
                if (fwd && (!i_tok.have_fwd || (r_start < i_tok.fwd_start))) begin
                    n_tok.have_fwd  = 1'b1;
                    n_tok.fwd_start = r_start;
                    n_tok.fwd_end   = r_end;
                    n_fwd_idx       = MY_IDX;
                end
                if (r_start < i_tok.small_start) begin
                    n_tok.small_start = r_start;
                    n_tok.small_end   = r_end;
                    n_small_idx       = MY_IDX;
                end
            end
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_fwd_idx   <= '0;
            r_small_idx <= '0;
        end else begin
            r_tok       <= n_tok;
            r_fwd_idx   <= n_fwd_idx;
            r_small_idx <= n_small_idx;
        end
    end

    assign o_tok       = r_tok;
    assign o_fwd_idx   = r_fwd_idx;
    assign o_small_idx = r_small_idx;

endmodule

// File: src/priority_elevator_request_picker.sv
// Request table with a C-LOOK pick. Insert, remove and unused command words load a
// result word into the output register, or park it while the output word is still held.
// A pick sends a search token down the row of TABLE_ENTRIES cells, one cell per cycle;
// the input is not ready again until the result has moved into the output register,
// so a stalled result channel holds off the next word for as long as the stall lasts.
// The token picks the highest eligible priority, then the nearest start sector at or
// beyond the last read sector, else the lowest start sector; ties go to the lowest
// slot. The user must write min_priority through the configuration port only while
// the block is idle; the block itself does not enforce it.
module priority_elevator_request_picker
    import pep_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pep_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pep_out          o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PRIO_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    t_pep_state                r_state;
    t_pep_state                n_state;
    logic [PRIO_W-1:0]         r_min_prio;
    logic signed [LAST_W-1:0]  r_last;
    logic                      r_out_valid;
    t_pep_out                  r_out_data;
    t_pep_out                  r_res;
    t_pep_out                  n_res;

    logic                      accept;
    logic                      can_load;
    logic                      out_load;
    t_pep_out                  out_word;
    logic                      launch;
    logic                      last_upd;

    logic [BYTE_W:0]           end_bytes;
    logic [SECTOR_W-1:0]       ins_start;
    logic [SECTOR_W-1:0]       ins_end;

    t_pep_tok                  tok_chain   [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]          fwd_chain   [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]          small_chain [TABLE_ENTRIES+1];
    t_pep_wr                   wr_cell     [TABLE_ENTRIES];

    t_pep_tok                  tok_end;
    logic [IDX_W-1:0]          pick_idx;
    logic [SECTOR_W-1:0]       pick_end;
    t_pep_out                  pick_word;

    assign accept = i_in_valid && o_in_ready;

    // Sector span of an inserted request
    always_comb begin
        end_bytes = {1'b0, i_in_data.byte_offset} + {1'b0, i_in_data.byte_size};
        ins_start = SECTOR_W'(i_in_data.file_start_sector)
                  + SECTOR_W'(i_in_data.byte_offset >> SECTOR_SHIFT);
        ins_end   = SECTOR_W'(i_in_data.file_start_sector)
                  + SECTOR_W'(end_bytes >> SECTOR_SHIFT);
    end

    // Seed the token at the head of the row
    always_comb begin
        tok_chain[0]     = '0;
        tok_chain[0].run = launch;
        fwd_chain[0]     = '0;
        small_chain[0]   = '0;
    end

    // Row of cells
    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        always_comb begin
            wr_cell[gi].ins       = accept && (i_in_data.cmd == CMD_INSERT)
                                  && (32'(i_in_data.slot) == 32'(gi));
            wr_cell[gi].rem       = accept && (i_in_data.cmd == CMD_REMOVE)
                                  && (32'(i_in_data.slot) == 32'(gi));
            wr_cell[gi].prio      = i_in_data.priority_req;
            wr_cell[gi].start_sec = ins_start;
            wr_cell[gi].end_sec   = ins_end;
        end

        pep_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (wr_cell[gi]),
            .i_min_prio  (r_min_prio),
            .i_last      (r_last),
            .i_tok       (tok_chain[gi]),
            .i_fwd_idx   (fwd_chain[gi]),
            .i_small_idx (small_chain[gi]),
            .o_tok       (tok_chain[gi+1]),
            .o_fwd_idx   (fwd_chain[gi+1]),
            .o_small_idx (small_chain[gi+1])
        );
    end

    // Resolve the token leaving the last cell
    always_comb begin
        tok_end  = tok_chain[TABLE_ENTRIES];
        pick_idx = tok_end.have_fwd ? fwd_chain[TABLE_ENTRIES] : small_chain[TABLE_ENTRIES];
        pick_end = tok_end.have_fwd ? tok_end.fwd_end : tok_end.small_end;
        pick_word.found       = tok_end.any;
        pick_word.picked_slot = tok_end.any ? SLOT_W'(pick_idx) : '0;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        out_word   = '0;
        launch     = 1'b0;
        last_upd   = 1'b0;
        can_load   = !r_out_valid || i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_data.cmd == CMD_PICK) begin
                        launch  = 1'b1;
                        n_state = ST_SCAN;
                    end else if (can_load) begin
                        out_load = 1'b1;
                    end else begin
                        n_res   = '0;
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_SCAN: begin
                if (tok_end.run) begin
                    last_upd = tok_end.any;
                    if (can_load) begin
                        out_load = 1'b1;
                        out_word = pick_word;
                        n_state  = ST_IDLE;
                    end else begin
                        n_res   = pick_word;
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (can_load) begin
                    out_load = 1'b1;
                    out_word = r_res;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Park a result while the output word is still held
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Track the last read sector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '1;
        end else if (last_upd) begin
            r_last <= $signed({1'b0, pick_end});
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_prio <= '0;
        end else if (i_cfg_valid) begin
            r_min_prio <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: src/pep_checker.sv
module pep_checker
    import pep_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_pep_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_pep_out o_out_data
);

    // Result word waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // Stalled result word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result word changed");

    // A miss reports slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.picked_slot == '0)
        else $error("result without a find carries a slot");

    // A pick holds off the next word while the row is searched
    a_pick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.cmd == CMD_PICK) |=> !o_in_ready)
        else $error("input taken during a pick");

    // No result word straight after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown after reset");

endmodule

bind priority_elevator_request_picker pep_checker u_pep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
